// File: hdl/kst_pkg.sv
// Package for the keyed slot table: sizes, command and status codes,
// and the beat and token structs shared by the cell and the top level.
// Depends on nothing.
package kst_pkg;

  localparam int SLOT_COUNT = 64;
  localparam int IDX_W      = $clog2(SLOT_COUNT);
  localparam int CNT_W      = $clog2(SLOT_COUNT + 1);

  localparam int KEY_W = 17;
  localparam int QTY_W = 17;
  localparam int WGT_W = 20;

  typedef enum logic [1:0] {
    CMD_CREATE = 2'd0,
    CMD_LOOKUP = 2'd1,
    CMD_DELETE = 2'd2
  } kst_cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } kst_status_t;

  typedef struct packed {
    logic [1:0]       command;
    logic [KEY_W-1:0] lot_key;
    logic [QTY_W-1:0] quantity_in;
    logic [WGT_W-1:0] weight_grams_in;
  } kst_in_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [5:0]       slot_index;
    logic [QTY_W-1:0] quantity_out;
    logic [WGT_W-1:0] weight_grams_out;
    logic [6:0]       valid_count;
  } kst_out_t;

  // The operation as it travels down the row of cells.
  typedef struct packed {
    logic             vld;
    logic [1:0]       cmd;
    logic [KEY_W-1:0] key;
    logic [QTY_W-1:0] qty;
    logic [WGT_W-1:0] wgt;
    logic             hit;
    logic [IDX_W-1:0] idx;
  } kst_token_t;

endpackage

// File: hdl/kst_cell.sv
// One slot of the keyed slot table: valid mark, key and payload, plus the
// token register that hands the operation on to the next cell.
// Depends on kst_pkg.
module kst_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [kst_pkg::IDX_W-1:0] cell_idx,
  input  kst_pkg::kst_token_t tok_i,
  output kst_pkg::kst_token_t tok_o
);
  import kst_pkg::*;

  logic             valid_r, valid_nxt;
  logic [KEY_W-1:0] key_r, key_nxt;
  logic [QTY_W-1:0] qty_r, qty_nxt;
  logic [WGT_W-1:0] wgt_r, wgt_nxt;
  kst_token_t       tok_r, tok_nxt;
  logic             take_free;
  logic             key_match;

  // Only the first qualifying cell acts; later cells see hit set.
  assign take_free = tok_i.vld && !tok_i.hit && (tok_i.cmd == CMD_CREATE) && !valid_r;
  assign key_match = tok_i.vld && !tok_i.hit && valid_r && (key_r == tok_i.key) &&
                     ((tok_i.cmd == CMD_LOOKUP) || (tok_i.cmd == CMD_DELETE));

  always_comb begin
    tok_nxt   = tok_i;
    valid_nxt = valid_r;
    key_nxt   = key_r;
    qty_nxt   = qty_r;
    wgt_nxt   = wgt_r;
    if (take_free) begin
      valid_nxt   = 1'b1;
      key_nxt     = tok_i.key;
      qty_nxt     = tok_i.qty;
      wgt_nxt     = tok_i.wgt;
      tok_nxt.hit = 1'b1;
      tok_nxt.idx = cell_idx;
    end else if (key_match) begin
      tok_nxt.hit = 1'b1;
      tok_nxt.idx = cell_idx;
      tok_nxt.qty = qty_r;
      tok_nxt.wgt = wgt_r;
      if (tok_i.cmd == CMD_DELETE) begin
        valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      tok_r.vld <= 1'b0;
    end else begin
      valid_r   <= valid_nxt;
      tok_r.vld <= tok_nxt.vld;
    end
    key_r     <= key_nxt;
    qty_r     <= qty_nxt;
    wgt_r     <= wgt_nxt;
    tok_r.cmd <= tok_nxt.cmd;
    tok_r.key <= tok_nxt.key;
    tok_r.qty <= tok_nxt.qty;
    tok_r.wgt <= tok_nxt.wgt;
    tok_r.hit <= tok_nxt.hit;
    tok_r.idx <= tok_nxt.idx;
  end

  assign tok_o = tok_r;

endmodule

// File: hdl/keyed_slot_table.sv
// Keyed slot table: each accepted command travels as a token down the row of cells,
// one cell a cycle, and the result strobe and beat are registered as the token
// leaves the last cell. A new command is taken only while busy is low, so the next
// waits until the last one has its result. Depends on kst_pkg and kst_cell.
// Reset (synchronous, rst_n low) clears every valid mark, the count and busy at once;
// keys and payloads are left as they are. Results are strobed and cannot be stalled.
module keyed_slot_table (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  kst_pkg::kst_in_t in_data,
  output logic             out_valid,
  output kst_pkg::kst_out_t out_data
);
  import kst_pkg::*;

  // The token chain: tok[0] is the command being injected, tok[i+1] is the
  // registered token leaving cell i. Only one token is ever in flight,
  // because a new beat is taken only once busy has dropped.
  kst_token_t tok [0:SLOT_COUNT];
  logic [SLOT_COUNT-1:0] tok_vld;

  logic       busy_r, busy_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic       out_valid_r, out_valid_nxt;
  kst_out_t   out_r, out_nxt;
  logic       accept;
  kst_token_t head;
  kst_token_t tail;

  assign accept = start && !busy_r;

  always_comb begin
    head.vld = accept;
    head.cmd = in_data.command;
    head.key = in_data.lot_key;
    head.qty = in_data.quantity_in;
    head.wgt = in_data.weight_grams_in;
    head.hit = 1'b0;
    head.idx = '0;
  end

  assign tok[0] = head;

  for (genvar i = 0; i < SLOT_COUNT; i++) begin : g_cell
    kst_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_idx (IDX_W'(i)),
      .tok_i    (tok[i]),
      .tok_o    (tok[i+1])
    );
    assign tok_vld[i] = tok[i+1].vld;
  end

  assign tail = tok[SLOT_COUNT];

  // When the token leaves the last cell the result beat is formed. A hit
  // means the operation succeeded; a miss is table full for a create and
  // key not found for anything else, including the unused command code.
  always_comb begin
    busy_nxt      = busy_r;
    count_nxt     = count_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    if (accept) begin
      busy_nxt = 1'b1;
    end
    if (tail.vld) begin
      busy_nxt      = 1'b0;
      out_valid_nxt = 1'b1;
      if (tail.hit && (tail.cmd == CMD_CREATE)) begin
        count_nxt = count_r + CNT_W'(1);
      end else if (tail.hit && (tail.cmd == CMD_DELETE)) begin
        count_nxt = count_r - CNT_W'(1);
      end
      if (tail.hit) begin
        out_nxt.status           = ST_OK;
        out_nxt.slot_index       = 6'(tail.idx);
        out_nxt.quantity_out     = tail.qty;
        out_nxt.weight_grams_out = tail.wgt;
      end else begin
        out_nxt.status           = (tail.cmd == CMD_CREATE) ? ST_FULL : ST_NOT_FOUND;
        out_nxt.slot_index       = '0;
        out_nxt.quantity_out     = '0;
        out_nxt.weight_grams_out = '0;
      end
      out_nxt.valid_count = 7'(count_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_r <= out_nxt;
  end

  assign busy      = busy_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef ASSERT_OFF
  a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(tok_vld))
    else $error("more than one command token in the cell chain");

  a_busy_ends_with_result: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy_r) |-> out_valid_r)
    else $error("busy dropped without a result beat");

  a_accept_sets_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy_r)
    else $error("accepted beat did not raise busy");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(SLOT_COUNT))
    else $error("valid slot count above table size");

  a_miss_payload_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_r.status != ST_OK)) |->
      (out_r.slot_index == '0) && (out_r.quantity_out == '0) &&
      (out_r.weight_grams_out == '0))
    else $error("failed operation reported a nonzero payload");
`endif

endmodule
